[rtl/core/kcm_pkg.sv]
// shared types and constants of the keyed context map
package kcm_pkg;

	localparam int HANDLE_W     = 32;
	localparam int ID_W         = 32;
	localparam int COUNT_W      = 7;
	localparam int CAPACITY_DEF = 64;
	localparam int KEY_BITS_DEF = 32;

	typedef enum logic [1:0] {
		FN_LOOKUP = 2'd0,
		FN_INSERT = 2'd1,
		FN_REMOVE = 2'd2,
		FN_RSVD   = 2'd3
	} func_e;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_NOT_FOUND = 2'd1,
		ST_DUPLICATE = 2'd2,
		ST_FULL      = 2'd3
	} status_e;

	// control part of a request traveling down the cell row
	typedef struct packed {
		logic  valid;
		func_e func;
		logic  hit;
		logic  free;
	} pkt_ctl_t;

	// table update broadcast from the tail to every cell
	typedef struct packed {
		logic wr;
		logic clr;
	} commit_t;

endpackage

[rtl/core/kcm_cell.sv]
// one entry of the map: stored key and handle plus the request stage passing through
module kcm_cell #(
	parameter int KEY_BITS = 32,
	parameter int IDX_W    = 6,
	parameter int CELL_IDX = 0
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  kcm_pkg::pkt_ctl_t        ctl_in,
	input  logic [KEY_BITS-1:0]      key_in,
	input  logic [kcm_pkg::HANDLE_W-1:0] lane_in,
	input  logic [IDX_W-1:0]         hit_idx_in,
	input  logic [IDX_W-1:0]         free_idx_in,
	output kcm_pkg::pkt_ctl_t        ctl_out,
	output logic [KEY_BITS-1:0]      key_out,
	output logic [kcm_pkg::HANDLE_W-1:0] lane_out,
	output logic [IDX_W-1:0]         hit_idx_out,
	output logic [IDX_W-1:0]         free_idx_out,
	input  kcm_pkg::commit_t         commit,
	input  logic [IDX_W-1:0]         cm_idx,
	input  logic [KEY_BITS-1:0]      cm_key,
	input  logic [kcm_pkg::HANDLE_W-1:0] cm_handle
);
	import kcm_pkg::*;

	localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

	logic                entry_vld_q;
	logic [KEY_BITS-1:0] entry_key_q;
	logic [HANDLE_W-1:0] entry_handle_q;

	logic                match;
	logic                take_free;
	pkt_ctl_t            ctl_nxt;
	logic [HANDLE_W-1:0] lane_nxt;
	logic [IDX_W-1:0]    hit_idx_nxt;
	logic [IDX_W-1:0]    free_idx_nxt;

	assign match     = entry_vld_q && (entry_key_q == key_in);
	assign take_free = !entry_vld_q && !ctl_in.free;

	always_comb begin
		ctl_nxt      = ctl_in;
		lane_nxt     = lane_in;
		hit_idx_nxt  = hit_idx_in;
		free_idx_nxt = free_idx_in;
		if (match && !ctl_in.hit) begin
			ctl_nxt.hit = 1'b1;
			hit_idx_nxt = MY_IDX;
			if (ctl_in.func == FN_LOOKUP) begin
				lane_nxt = entry_handle_q;
			end
		end
		if (take_free) begin
			ctl_nxt.free = 1'b1;
			free_idx_nxt = MY_IDX;
		end
	end

	// request stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_out <= '0;
		end else begin
			ctl_out <= ctl_nxt;
		end
	end

	always_ff @(posedge clk) begin
		key_out      <= key_in;
		lane_out     <= lane_nxt;
		hit_idx_out  <= hit_idx_nxt;
		free_idx_out <= free_idx_nxt;
	end

	// entry storage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_vld_q <= 1'b0;
		end else if (cm_idx == MY_IDX) begin
			if (commit.wr) begin
				entry_vld_q <= 1'b1;
			end else if (commit.clr) begin
				entry_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (commit.wr && (cm_idx == MY_IDX)) begin
			entry_key_q    <= cm_key;
			entry_handle_q <= cm_handle;
		end
	end

endmodule

[rtl/core/keyed_context_map_top.sv]
// keyed context map: a row of entry cells searched by a request passing through them
// flow: an accepted request walks the cell row (one cell per cycle) into the tail register,
//   which commits it to the output register once that is free or being drained; only one
//   request is in the row at a time, and the next beat is taken once the tail commits,
//   even while that result still waits in the output register
// reset: arst_n clears every entry valid bit, the count and all handshake state at once
module keyed_context_map_top #(
	parameter int CAPACITY = kcm_pkg::CAPACITY_DEF,
	parameter int KEY_BITS = kcm_pkg::KEY_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,  // [31:0] key_id, [63:32] handle_in
	input  logic [1:0]  s_tuser,  // [1:0] func
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,  // [31:0] handle_out, [38:32] entry_count, [39] zero
	output logic [1:0]  m_tuser   // [1:0] status
);
	import kcm_pkg::*;

	localparam int IDX_W = $clog2(CAPACITY);
	localparam int CNT_W = $clog2(CAPACITY + 1);

	// links between neighboring cells; link 0 is the request entering the row
	pkt_ctl_t            ctl_c      [CAPACITY+1];
	logic [KEY_BITS-1:0] key_c      [CAPACITY+1];
	logic [HANDLE_W-1:0] lane_c     [CAPACITY+1];
	logic [IDX_W-1:0]    hit_idx_c  [CAPACITY+1];
	logic [IDX_W-1:0]    free_idx_c [CAPACITY+1];

	// tail register catching the request as it leaves the last cell
	logic                tail_vld_q;
	func_e               tail_func_q;
	logic                tail_hit_q;
	logic                tail_free_q;
	logic [KEY_BITS-1:0] tail_key_q;
	logic [HANDLE_W-1:0] tail_lane_q;
	logic [IDX_W-1:0]    tail_hit_idx_q;
	logic [IDX_W-1:0]    tail_free_idx_q;

	logic                busy_q;
	logic [CNT_W-1:0]    count_q;
	logic                m_vld_q;
	logic [39:0]         m_data_q;
	logic [1:0]          m_user_q;

	logic                fire;
	commit_t             commit;
	logic [IDX_W-1:0]    cm_idx;
	status_e             status;
	logic [HANDLE_W-1:0] handle_res;
	logic [CNT_W-1:0]    count_nxt;

	// one request in the row at a time; the table is settled before the next enters
	assign s_tready = !busy_q;

	always_comb begin
		ctl_c[0].valid = s_tvalid && s_tready;
		ctl_c[0].func  = func_e'(s_tuser);
		ctl_c[0].hit   = 1'b0;
		ctl_c[0].free  = 1'b0;
	end
	// key bits at and above KEY_BITS are dropped, or zero filled for wide keys
	assign key_c[0]      = KEY_BITS'(s_tdata[ID_W-1:0]);
	assign lane_c[0]     = s_tdata[63:32];
	assign hit_idx_c[0]  = '0;
	assign free_idx_c[0] = '0;

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		kcm_cell #(
			.KEY_BITS (KEY_BITS),
			.IDX_W    (IDX_W),
			.CELL_IDX (i)
		) u_cell (
			.clk          (clk),
			.arst_n       (arst_n),
			.ctl_in       (ctl_c[i]),
			.key_in       (key_c[i]),
			.lane_in      (lane_c[i]),
			.hit_idx_in   (hit_idx_c[i]),
			.free_idx_in  (free_idx_c[i]),
			.ctl_out      (ctl_c[i+1]),
			.key_out      (key_c[i+1]),
			.lane_out     (lane_c[i+1]),
			.hit_idx_out  (hit_idx_c[i+1]),
			.free_idx_out (free_idx_c[i+1]),
			.commit       (commit),
			.cm_idx       (cm_idx),
			.cm_key       (tail_key_q),
			.cm_handle    (tail_lane_q)
		);
	end

	// tail commits when the output register is free or being drained
	assign fire = tail_vld_q && (!m_vld_q || m_tready);

	// decide the outcome from what the walk collected
	always_comb begin
		status     = ST_NOT_FOUND;
		commit     = '0;
		cm_idx     = tail_hit_idx_q;
		handle_res = '0;
		case (tail_func_q)
			FN_LOOKUP: begin
				if (tail_hit_q) begin
					status     = ST_OK;
					handle_res = tail_lane_q;
				end
			end
			FN_INSERT: begin
				cm_idx = tail_free_idx_q;
				if (tail_hit_q) begin
					status = ST_DUPLICATE;
				end else if (tail_free_q) begin
					status    = ST_OK;
					commit.wr = fire;
				end else begin
					status = ST_FULL;
				end
			end
			FN_REMOVE: begin
				if (tail_hit_q) begin
					status     = ST_OK;
					commit.clr = fire;
				end
			end
			default: begin
				status = ST_NOT_FOUND;
			end
		endcase
	end

	always_comb begin
		count_nxt = count_q;
		if (commit.wr) begin
			count_nxt = count_q + CNT_W'(1);
		end else if (commit.clr && (count_q != '0)) begin
			count_nxt = count_q - CNT_W'(1);
		end
	end

	// request in flight and tail capture
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q     <= 1'b0;
			tail_vld_q <= 1'b0;
			count_q    <= '0;
		end else begin
			if (s_tvalid && s_tready) begin
				busy_q <= 1'b1;
			end else if (fire) begin
				busy_q <= 1'b0;
			end
			if (ctl_c[CAPACITY].valid) begin
				tail_vld_q <= 1'b1;
			end else if (fire) begin
				tail_vld_q <= 1'b0;
			end
			count_q <= count_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl_c[CAPACITY].valid) begin
			tail_func_q     <= ctl_c[CAPACITY].func;
			tail_hit_q      <= ctl_c[CAPACITY].hit;
			tail_free_q     <= ctl_c[CAPACITY].free;
			tail_key_q      <= key_c[CAPACITY];
			tail_lane_q     <= lane_c[CAPACITY];
			tail_hit_idx_q  <= hit_idx_c[CAPACITY];
			tail_free_idx_q <= free_idx_c[CAPACITY];
		end
	end

	// output register; result beat holds until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_vld_q <= 1'b0;
		end else if (fire) begin
			m_vld_q <= 1'b1;
		end else if (m_tready) begin
			m_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			m_data_q <= {1'b0, COUNT_W'(count_nxt), handle_res};
			m_user_q <= status;
		end
	end

	assign m_tvalid = m_vld_q;
	assign m_tdata  = m_data_q;
	assign m_tuser  = m_user_q;

endmodule

[test/keyed_context_map_top_tb.sv]
// self-checking testbench of the keyed context map: directed and random table traffic
`timescale 1ns / 1ps

module keyed_context_map_top_tb;
	import kcm_pkg::*;

	localparam int CAPACITY  = CAPACITY_DEF;
	localparam int KEY_BITS  = KEY_BITS_DEF;
	localparam logic [63:0] KEY_MASK = (64'd1 << KEY_BITS) - 64'd1;
	localparam int POOL_SIZE = 96;       // more keys than entries, so the table can fill
	localparam int HOLD_AT   = 30;       // result beat after which the sink holds off
	localparam int HOLD_LEN  = 500;      // length of that hold-off in cycles
	localparam int DRAIN     = CAPACITY + 8;
	localparam int WD_LIMIT  = 4000;     // cycles with no beat on either side

	// how the two sides idle while a request is in play
	typedef enum logic [1:0] {
		PACE_FREE,
		PACE_SRC_IDLE,
		PACE_SNK_STALL,
		PACE_BOTH
	} pace_e;

	typedef struct packed {
		func_e       func;
		logic [31:0] key_id;
		logic [31:0] handle_in;
		pace_e       pace;
	} map_req_t;

	typedef struct packed {
		status_e     status;
		logic [31:0] handle_out;
		logic [6:0]  entry_count;
	} map_rsp_t;

	logic        clk;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [63:0] s_tdata  = '0;     // [31:0] key_id, [63:32] handle_in
	logic [1:0]  s_tuser  = '0;     // [1:0] func
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [39:0] m_tdata;           // [31:0] handle_out, [38:32] entry_count, [39] zero
	logic [1:0]  m_tuser;           // [1:0] status

	// predicted table contents
	logic        ent_valid [CAPACITY];
	logic [31:0] ent_key   [CAPACITY];
	logic [31:0] ent_handle[CAPACITY];
	int          held_count;

	map_req_t    pending_req_q[$];
	map_rsp_t    expected_rsp_q[$];
	map_req_t    in_flight;
	map_req_t    next_req;
	pace_e       cur_pace = PACE_FREE;
	logic [31:0] key_pool[POOL_SIZE];

	int errors    = 0;
	int out_beats = 0;
	int hold_cnt  = 0;
	bit hold_done = 1'b0;
	int idle_cnt  = 0;

	keyed_context_map_top u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// apply one request to the predicted table and return the result it gives
	function automatic map_rsp_t map_access(map_req_t req);
		map_rsp_t    rsp;
		logic [31:0] key;
		int          hit;
		int          slot;
		key             = req.key_id & KEY_MASK[31:0];
		hit             = -1;
		slot            = -1;
		rsp.status      = ST_NOT_FOUND;
		rsp.handle_out  = '0;
		// lowest matching valid entry and lowest free entry, as the walk through the cell row picks
		for (int i = 0; i < CAPACITY; i++) begin
			if (hit < 0 && ent_valid[i] && ent_key[i] == key)
				hit = i;
			if (slot < 0 && !ent_valid[i])
				slot = i;
		end
		case (req.func)
			FN_LOOKUP: begin
				if (hit >= 0) begin
					rsp.status     = ST_OK;
					rsp.handle_out = ent_handle[hit];
				end
			end
			FN_INSERT: begin
				if (hit >= 0) begin
					rsp.status = ST_DUPLICATE;      // stored handle is kept
				end else if (slot < 0) begin
					rsp.status = ST_FULL;           // table left unchanged
				end else begin
					ent_valid[slot]  = 1'b1;
					ent_key[slot]    = key;
					ent_handle[slot] = req.handle_in;
					held_count++;
					rsp.status = ST_OK;
				end
			end
			FN_REMOVE: begin
				if (hit >= 0) begin
					ent_valid[hit] = 1'b0;
					if (held_count > 0)
						held_count--;
					rsp.status = ST_OK;
				end
			end
			default: ;                               // unused code: no change, not found
		endcase
		rsp.entry_count = 7'(held_count);
		return rsp;
	endfunction

	task automatic queue_request(func_e func, logic [31:0] key_id, logic [31:0] handle_in,
			pace_e pace);
		map_req_t req;
		req.func      = func;
		req.key_id    = key_id;
		req.handle_in = handle_in;
		req.pace      = pace;
		pending_req_q.push_back(req);
	endtask

	// request driver: the accepted beat goes into the predictor, then the next one is offered
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= '0;
			s_tuser  <= FN_LOOKUP;
		end else begin
			if (s_tvalid && s_tready)
				expected_rsp_q.push_back(map_access(in_flight));
			if (!s_tvalid || s_tready) begin
				// sender idles according to the pace of the request next in line
				if (pending_req_q.size() != 0 &&
						!((pending_req_q[0].pace == PACE_SRC_IDLE && $urandom_range(99) < 68) ||
						  (pending_req_q[0].pace == PACE_BOTH && $urandom_range(99) < 34))) begin
					next_req  = pending_req_q.pop_front();
					in_flight = next_req;
					s_tvalid <= 1'b1;
					s_tdata  <= {next_req.handle_in, next_req.key_id};
					s_tuser  <= next_req.func;
					cur_pace <= next_req.pace;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// result sink ready: random stalls by pace, plus one long hold-off so the block backs up
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready  <= 1'b0;
			hold_cnt  <= 0;
			hold_done <= 1'b0;
		end else begin
			if (hold_cnt != 0) begin
				hold_cnt <= hold_cnt - 1;
				m_tready <= 1'b0;
			end else if (!hold_done && out_beats >= HOLD_AT) begin
				hold_cnt  <= HOLD_LEN;
				hold_done <= 1'b1;
				m_tready  <= 1'b0;
			end else begin
				m_tready <= !((cur_pace == PACE_SNK_STALL && $urandom_range(99) < 68) ||
				              (cur_pace == PACE_BOTH && $urandom_range(99) < 34));
			end
		end
	end

	// result monitor: each beat against the oldest expectation, field by field
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			out_beats <= out_beats + 1;
			if (expected_rsp_q.size() == 0) begin
				$error("result beat with no request waiting: status %0d handle_out %h",
					m_tuser, m_tdata[31:0]);
				errors++;
			end else begin
				map_rsp_t exp_rsp;
				exp_rsp = expected_rsp_q.pop_front();
				if (m_tuser !== exp_rsp.status) begin
					$error("status: expected %0d, actual %0d", exp_rsp.status, m_tuser);
					errors++;
				end
				if (m_tdata[31:0] !== exp_rsp.handle_out) begin
					$error("handle_out: expected %h, actual %h", exp_rsp.handle_out,
						m_tdata[31:0]);
					errors++;
				end
				if (m_tdata[38:32] !== exp_rsp.entry_count) begin
					$error("entry_count: expected %0d, actual %0d", exp_rsp.entry_count,
						m_tdata[38:32]);
					errors++;
				end
				if (m_tdata[39] !== 1'b0) begin
					$error("pad bit: expected 0, actual %b", m_tdata[39]);
					errors++;
				end
			end
		end
	end

	// watchdog: too long with no beat on either side means the block is stuck
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
				idle_cnt <= 0;
			end else if (idle_cnt >= WD_LIMIT) begin
				$display("CHECK FAILED");
				$finish;
			end else begin
				idle_cnt <= idle_cnt + 1;
			end
		end
	end

	initial begin
		int ins_pct [8];
		int rem_pct [8];
		int pick;
		logic [31:0] key;
		func_e func;

		for (int i = 0; i < CAPACITY; i++) begin
			ent_valid[i]  = 1'b0;
			ent_key[i]    = '0;
			ent_handle[i] = '0;
		end
		held_count = 0;

		// key pool holds the all-zero and all-one ids plus random ones
		key_pool[0] = 32'h0000_0000;
		key_pool[1] = 32'hFFFF_FFFF;
		for (int i = 2; i < POOL_SIZE; i++)
			key_pool[i] = $urandom;

		// directed: empty table, unused code, field extremes, duplicate, hit and miss
		queue_request(FN_LOOKUP, 32'h0000_0000, 32'h0000_0000, PACE_FREE);
		queue_request(FN_REMOVE, 32'h0000_0000, 32'hFFFF_FFFF, PACE_FREE);
		queue_request(FN_RSVD,   32'hFFFF_FFFF, 32'hFFFF_FFFF, PACE_FREE);
		queue_request(FN_INSERT, 32'h0000_0000, 32'h0000_0000, PACE_FREE);
		queue_request(FN_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, PACE_FREE);
		queue_request(FN_INSERT, 32'h0000_0000, 32'h1234_5678, PACE_FREE);
		queue_request(FN_LOOKUP, 32'h0000_0000, 32'hFFFF_FFFF, PACE_FREE);
		queue_request(FN_LOOKUP, 32'hFFFF_FFFF, 32'h0000_0000, PACE_FREE);
		queue_request(FN_INSERT, 32'hA5A5_A5A5, 32'h5A5A_5A5A, PACE_FREE);
		queue_request(FN_INSERT, 32'h5A5A_5A5A, 32'hA5A5_A5A5, PACE_FREE);
		queue_request(FN_LOOKUP, 32'h5A5A_5A5A, 32'h0000_0000, PACE_FREE);
		queue_request(FN_RSVD,   32'h5A5A_5A5A, 32'h0000_0001, PACE_FREE);
		queue_request(FN_LOOKUP, 32'h5A5A_5A5A, 32'h0000_0000, PACE_FREE);
		queue_request(FN_REMOVE, 32'h0000_0000, 32'h0000_0000, PACE_FREE);
		queue_request(FN_LOOKUP, 32'h0000_0000, 32'h0000_0000, PACE_FREE);
		queue_request(FN_REMOVE, 32'h0000_0000, 32'h0000_0000, PACE_FREE);
		// freed lowest entry is reused by the next insert
		queue_request(FN_INSERT, 32'h0000_0000, 32'h0000_0001, PACE_FREE);
		queue_request(FN_LOOKUP, 32'h0000_0000, 32'h0000_0000, PACE_FREE);
		queue_request(FN_REMOVE, 32'hFFFF_FFFF, 32'h0000_0000, PACE_FREE);
		queue_request(FN_REMOVE, 32'hA5A5_A5A5, 32'h0000_0000, PACE_FREE);
		queue_request(FN_REMOVE, 32'h5A5A_5A5A, 32'h0000_0000, PACE_FREE);
		queue_request(FN_REMOVE, 32'h0000_0000, 32'h0000_0000, PACE_FREE);

		// fill past capacity so the full-table case is certain, then probe
		for (int i = 0; i < CAPACITY + 8; i++)
			queue_request(FN_INSERT, key_pool[i], $urandom, PACE_FREE);
		for (int i = 0; i < 8; i++)
			queue_request(FN_LOOKUP, key_pool[$urandom_range(POOL_SIZE - 1)], $urandom,
				PACE_FREE);

		// random phases with shifting operation mix; pace cycles through all idling modes
		ins_pct = '{50, 30, 20, 60, 35, 25, 45, 30};
		rem_pct = '{20, 30, 55, 15, 35, 50, 25, 30};
		for (int ph = 0; ph < 8; ph++) begin
			for (int n = 0; n < 160; n++) begin
				pick = $urandom_range(99);
				if (pick < 5)
					func = FN_RSVD;
				else if (pick < 5 + ins_pct[ph])
					func = FN_INSERT;
				else if (pick < 5 + ins_pct[ph] + rem_pct[ph])
					func = FN_REMOVE;
				else
					func = FN_LOOKUP;
				// mostly pool keys so hits, duplicates and removes land
				if ($urandom_range(9) == 0)
					key = $urandom;
				else
					key = key_pool[$urandom_range(POOL_SIZE - 1)];
				queue_request(func, key, $urandom, pace_e'(ph % 4));
			end
		end

		repeat (6) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		// drain: everything sent and every result back, then a quiet tail before the verdict
		while (pending_req_q.size() != 0 || s_tvalid || expected_rsp_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN) @(posedge clk);

		if (errors == 0 && expected_rsp_q.size() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
